// ===== hw/rtl/torus_point_transform_project_defines.svh =====
// assertion macros for the torus point transform
`ifndef TORUS_POINT_TRANSFORM_PROJECT_DEFINES_SVH
`define TORUS_POINT_TRANSFORM_PROJECT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TPT_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TPT_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/tpt_pkg.sv =====
// types, constants and fixed-point helper for the torus point transform
package tpt_pkg;

    localparam int TRIG_W    = 16;
    localparam int VAL_W     = 32;
    localparam int PROD_W    = 48;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 48;
    localparam int PIX_X_W   = 11;
    localparam int PIX_Y_W   = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_OBJ_ROT_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJ_ROT_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJ_ROT_Z = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ROT_X = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ROT_Z = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_POS = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJ_POS = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE = 4'd7;

    localparam logic [31:0] ROT_RESET       = 32'h4000_0000;
    localparam logic [47:0] VIEW_POS_RESET  = 48'h0000_F000_0000;
    localparam logic [47:0] OBJ_POS_RESET   = 48'h0000_3000_0000;
    localparam logic [47:0] SHAPE_RESET     = 48'h3000_1000_1000;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_tube;
        logic signed [TRIG_W-1:0] sin_tube;
        logic signed [TRIG_W-1:0] cos_ring;
        logic signed [TRIG_W-1:0] sin_ring;
    } tpt_in_t;

    typedef struct packed {
        logic [PIX_X_W-1:0] pixel_x;
        logic [PIX_Y_W-1:0] pixel_y;
        logic               visible;
    } tpt_out_t;

    // Q.12 length times Q1.14 trig, rounded half up back to Q.12
    function automatic logic signed [VAL_W-1:0] tm(input logic signed [VAL_W-1:0] a,
                                                   input logic signed [TRIG_W-1:0] t);
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] w;
        p = a * t;
        w = p + 48'sd8192;
        return w[VAL_W+13:14];
    endfunction

endpackage

// ===== hw/rtl/tpt_div2.sv =====
// two-lane pipelined restoring divider with shared divisor, one quotient bit per stage
module tpt_div2 #(
    parameter int DEN_W = 32,
    parameter int Q_W   = 13,
    parameter int TAG_W = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic [DEN_W-1:0]       den,
    input  logic [DEN_W+Q_W-1:0]   num_a,
    input  logic [DEN_W+Q_W-1:0]   num_b,
    input  logic [TAG_W-1:0]       tag,
    output logic                   out_vld,
    output logic [Q_W-1:0]         quo_a,
    output logic [Q_W-1:0]         quo_b,
    output logic [TAG_W-1:0]       tag_out
);

    localparam int R_W = DEN_W + Q_W;

    logic [R_W-1:0]   rem_a_reg [Q_W];
    logic [R_W-1:0]   rem_b_reg [Q_W];
    logic [Q_W-1:0]   qa_reg [Q_W];
    logic [Q_W-1:0]   qb_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [TAG_W-1:0] tag_reg [Q_W];
    logic [Q_W-1:0]   vld_reg;

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        logic [R_W-1:0]   ra_prev;
        logic [R_W-1:0]   rb_prev;
        logic [R_W-1:0]   trial;
        logic [R_W-1:0]   ra_next;
        logic [R_W-1:0]   rb_next;
        logic [Q_W-1:0]   qa_prev;
        logic [Q_W-1:0]   qb_prev;
        logic [Q_W-1:0]   qa_next;
        logic [Q_W-1:0]   qb_next;
        logic [DEN_W-1:0] d_prev;
        logic [TAG_W-1:0] t_prev;
        logic             v_prev;

        if (i == 0) begin : g_first
            assign ra_prev = num_a;
            assign rb_prev = num_b;
            assign qa_prev = '0;
            assign qb_prev = '0;
            assign d_prev  = den;
            assign t_prev  = tag;
            assign v_prev  = in_vld;
        end else begin : g_next
            assign ra_prev = rem_a_reg[i-1];
            assign rb_prev = rem_b_reg[i-1];
            assign qa_prev = qa_reg[i-1];
            assign qb_prev = qb_reg[i-1];
            assign d_prev  = den_reg[i-1];
            assign t_prev  = tag_reg[i-1];
            assign v_prev  = vld_reg[i-1];
        end

        always_comb
        begin
            trial   = R_W'(d_prev) << (Q_W - 1 - i);
            ra_next = ra_prev;
            rb_next = rb_prev;
            qa_next = qa_prev;
            qb_next = qb_prev;
            if (ra_prev >= trial)
            begin
                ra_next = ra_prev - trial;
                qa_next[Q_W-1-i] = 1'b1;
            end
            if (rb_prev >= trial)
            begin
                rb_next = rb_prev - trial;
                qb_next[Q_W-1-i] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_a_reg[i] <= ra_next;
                rem_b_reg[i] <= rb_next;
                qa_reg[i]    <= qa_next;
                qb_reg[i]    <= qb_next;
                den_reg[i]   <= d_prev;
                tag_reg[i]   <= t_prev;
            end
        end
    end

    assign out_vld = vld_reg[Q_W-1];
    assign quo_a   = qa_reg[Q_W-1];
    assign quo_b   = qb_reg[Q_W-1];
    assign tag_out = tag_reg[Q_W-1];

endmodule

// ===== hw/rtl/torus_point_transform_project.sv =====
// top level: torus point transform, camera transform and perspective projection
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+----------------------------------
//  in      | to block  | in_valid / in_ready   | in_data: tube and ring cos/sin
//  out     | from block| out_valid / out_ready | out_data: pixel_x, pixel_y, visible
//  cfg     | to block  | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
//  one word per cycle while out is empty or its word is taken; the screen divider
//  pipeline makes one quotient bit per stage; pixel scaling is a reciprocal multiply
//  all stages advance together; when out holds a word not taken, everything holds
//  reset clears valid bits and loads the register defaults; no clearing pass
`include "torus_point_transform_project_defines.svh"

module torus_point_transform_project
    import tpt_pkg::*;
#(
    parameter int PIXELS_X      = 1280,
    parameter int PIXELS_Y      = 720,
    parameter int VIEW_SPAN_Q12 = 16384
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tpt_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tpt_out_t             out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int HALF   = VIEW_SPAN_Q12 / 2;
    localparam int QS_W   = $clog2(HALF);
    localparam int SP_W   = $clog2(2 * HALF + 1);
    localparam int SS_W   = SP_W + 1;
    localparam int PX_MAX = (PIXELS_X > PIXELS_Y) ? PIXELS_X : PIXELS_Y;
    localparam int QP_W   = $clog2(PX_MAX);
    localparam int D1_R   = VAL_W + QS_W;
    localparam int D2_R   = SP_W + QP_W;
    localparam int NSTG   = 10;
    // reciprocal of the span, exact floor for every product below 2^D2_R
    localparam int RC_K   = D2_R + $clog2(2 * HALF);
    localparam int RC_W   = D2_R + 1;
    localparam logic [63:0] RC_M = ((64'd1 << RC_K) + 64'(2 * HALF) - 64'd1)
                                   / 64'(2 * HALF);
    localparam int P3_W   = D2_R + RC_W;

    // configuration registers
    logic [31:0] obj_rx_reg, obj_ry_reg, obj_rz_reg, view_rx_reg, view_rz_reg;
    logic [47:0] view_pos_reg, obj_pos_reg, shape_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_rx_reg   <= ROT_RESET;
            obj_ry_reg   <= ROT_RESET;
            obj_rz_reg   <= ROT_RESET;
            view_rx_reg  <= ROT_RESET;
            view_rz_reg  <= ROT_RESET;
            view_pos_reg <= VIEW_POS_RESET;
            obj_pos_reg  <= OBJ_POS_RESET;
            shape_reg    <= SHAPE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OBJ_ROT_X:  obj_rx_reg   <= cfg_data[31:0];
                CFG_OBJ_ROT_Y:  obj_ry_reg   <= cfg_data[31:0];
                CFG_OBJ_ROT_Z:  obj_rz_reg   <= cfg_data[31:0];
                CFG_VIEW_ROT_X: view_rx_reg  <= cfg_data[31:0];
                CFG_VIEW_ROT_Z: view_rz_reg  <= cfg_data[31:0];
                CFG_VIEW_POS:   view_pos_reg <= cfg_data;
                CFG_OBJ_POS:    obj_pos_reg  <= cfg_data;
                CFG_SHAPE:      shape_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [TRIG_W-1:0] cx, sx, cy, sy, cz, sz, vcx, vsx, vcz, vsz;
    logic signed [TRIG_W-1:0] camx, camy, camz, ox, oy, oz, rmaj, rmin, foc;

    assign cx   = $signed(obj_rx_reg[31:16]);
    assign sx   = $signed(obj_rx_reg[15:0]);
    assign cy   = $signed(obj_ry_reg[31:16]);
    assign sy   = $signed(obj_ry_reg[15:0]);
    assign cz   = $signed(obj_rz_reg[31:16]);
    assign sz   = $signed(obj_rz_reg[15:0]);
    assign vcx  = $signed(view_rx_reg[31:16]);
    assign vsx  = $signed(view_rx_reg[15:0]);
    assign vcz  = $signed(view_rz_reg[31:16]);
    assign vsz  = $signed(view_rz_reg[15:0]);
    assign camx = $signed(view_pos_reg[47:32]);
    assign camy = $signed(view_pos_reg[31:16]);
    assign camz = $signed(view_pos_reg[15:0]);
    assign ox   = $signed(obj_pos_reg[47:32]);
    assign oy   = $signed(obj_pos_reg[31:16]);
    assign oz   = $signed(obj_pos_reg[15:0]);
    assign rmaj = $signed(shape_reg[47:32]);
    assign rmin = $signed(shape_reg[31:16]);
    assign foc  = $signed(shape_reg[15:0]);

    // pipeline control
    logic            adv;
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [2:0]      p_reg;
    logic [2:0]      p_next;
    logic            d1_vld;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;
    assign v_next   = {v_reg[NSTG-2:0], in_valid};
    assign p_next   = {p_reg[1:0], d1_vld};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            p_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= v_next;
            p_reg <= p_next;
        end
    end

    // stage datapath signals
    logic signed [VAL_W-1:0]  s1_rr_reg, s1_ms_reg, s1_rr_next, s1_ms_next;
    logic signed [TRIG_W-1:0] s1_cp_reg, s1_sp_reg;
    logic signed [VAL_W-1:0]  s2_rc_reg, s2_rs_reg, s2_ms_reg, s2_rc_next, s2_rs_next;
    logic signed [VAL_W-1:0]  s3_a_reg, s3_b_reg, s3_c_reg, s3_d_reg, s3_zr_reg;
    logic signed [VAL_W-1:0]  s3_a_next, s3_b_next, s3_c_next, s3_d_next, s3_zr_next;
    logic signed [VAL_W-1:0]  s4_u_reg, s4_pz_reg, s4_c_reg, s4_d_reg, s4_u_next, s4_pz_next;
    logic signed [VAL_W-1:0]  s5_dx_reg, s5_dy_reg, s5_dz_reg;
    logic signed [VAL_W-1:0]  s5_dx_next, s5_dy_next, s5_dz_next;
    logic signed [VAL_W-1:0]  s6_dx_reg, s6_g_reg, s6_nz_reg, s6_g_next, s6_nz_next;
    logic signed [VAL_W-1:0]  s7_nx_reg, s7_dep_reg, s7_nz_reg, s7_nx_next, s7_dep_next;
    logic signed [PROD_W-1:0] s8_mx_reg, s8_my_reg, s8_mx_next, s8_my_next;
    logic [VAL_W-1:0]         s8_ad_reg, s8_ad_next;
    logic                     s8_zero_reg;
    logic [PROD_W-1:0]        s9_anx_reg, s9_any_reg, s9_lim_reg;
    logic [PROD_W-1:0]        s9_anx_next, s9_any_next, s9_lim_next;
    logic [VAL_W-1:0]         s9_ad_reg;
    logic                     s9_sgx_reg, s9_sgy_reg, s9_zero_reg;
    logic                     s10_vis_reg, s10_vis_next, s10_sgx_reg, s10_sgy_reg;
    logic [D1_R-1:0]          s10_na_reg, s10_nb_reg, s10_na_next, s10_nb_next;
    logic [VAL_W-1:0]         s10_den_reg;

    always_comb
    begin
        s1_rr_next  = tm(VAL_W'(rmin), in_data.cos_tube) + VAL_W'(rmaj);
        s1_ms_next  = tm(VAL_W'(rmin), in_data.sin_tube);
        s2_rc_next  = tm(s1_rr_reg, s1_cp_reg);
        s2_rs_next  = tm(s1_rr_reg, s1_sp_reg);
        s3_a_next   = tm(s2_rc_reg, cy);
        s3_b_next   = tm(s2_rs_reg, cx) - tm(s2_ms_reg, sx);
        s3_c_next   = tm(s2_ms_reg, cx) + tm(s2_rs_reg, sx);
        s3_d_next   = tm(s2_rc_reg, cy) - tm(s2_ms_reg, sx);
        s3_zr_next  = tm(s2_rc_reg, sy);
        s4_u_next   = s3_a_reg - tm(s3_b_reg, sy);
        s4_pz_next  = s3_zr_reg + tm(s3_b_reg, cy) + VAL_W'(oz);
        s5_dx_next  = tm(s4_u_reg, cz) + tm(s4_c_reg, sz) + VAL_W'(ox) - VAL_W'(camx);
        s5_dy_next  = tm(s4_c_reg, cz) + tm(s4_d_reg, sz) + VAL_W'(oy) - VAL_W'(camy)
                    + VAL_W'(foc);
        s5_dz_next  = s4_pz_reg - VAL_W'(camz);
        s6_nz_next  = tm(s5_dz_reg, vcx) - tm(s5_dy_reg, vsx) - VAL_W'(camz);
        s6_g_next   = tm(s5_dy_reg, vcx) + tm(s5_dz_reg, vsx);
        s7_nx_next  = tm(s6_dx_reg, vcz) + tm(s6_g_reg, vsz) - VAL_W'(camx);
        s7_dep_next = tm(s6_g_reg, vcz) - tm(s6_dx_reg, vsz) - VAL_W'(camy) + VAL_W'(foc);
        s8_mx_next  = s7_nx_reg * foc;
        s8_my_next  = s7_nz_reg * foc;
        s8_ad_next  = (s7_dep_reg < 0) ? $unsigned(-s7_dep_reg) : $unsigned(s7_dep_reg);
        s9_anx_next = (s8_mx_reg < 0) ? $unsigned(-s8_mx_reg) : $unsigned(s8_mx_reg);
        s9_any_next = (s8_my_reg < 0) ? $unsigned(-s8_my_reg) : $unsigned(s8_my_reg);
        s9_lim_next = PROD_W'(HALF) * PROD_W'(s8_ad_reg);
        // inside the view square means the quotient magnitude stays below half span
        s10_vis_next = !s9_zero_reg && (s9_anx_reg < s9_lim_reg) && (s9_any_reg < s9_lim_reg);
        s10_na_next  = s10_vis_next ? D1_R'(s9_anx_reg) : '0;
        s10_nb_next  = s10_vis_next ? D1_R'(s9_any_reg) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_rr_reg   <= s1_rr_next;
            s1_ms_reg   <= s1_ms_next;
            s1_cp_reg   <= in_data.cos_ring;
            s1_sp_reg   <= in_data.sin_ring;
            s2_rc_reg   <= s2_rc_next;
            s2_rs_reg   <= s2_rs_next;
            s2_ms_reg   <= s1_ms_reg;
            s3_a_reg    <= s3_a_next;
            s3_b_reg    <= s3_b_next;
            s3_c_reg    <= s3_c_next;
            s3_d_reg    <= s3_d_next;
            s3_zr_reg   <= s3_zr_next;
            s4_u_reg    <= s4_u_next;
            s4_pz_reg   <= s4_pz_next;
            s4_c_reg    <= s3_c_reg;
            s4_d_reg    <= s3_d_reg;
            s5_dx_reg   <= s5_dx_next;
            s5_dy_reg   <= s5_dy_next;
            s5_dz_reg   <= s5_dz_next;
            s6_dx_reg   <= s5_dx_reg;
            s6_g_reg    <= s6_g_next;
            s6_nz_reg   <= s6_nz_next;
            s7_nx_reg   <= s7_nx_next;
            s7_dep_reg  <= s7_dep_next;
            s7_nz_reg   <= s6_nz_reg;
            s8_mx_reg   <= s8_mx_next;
            s8_my_reg   <= s8_my_next;
            s8_ad_reg   <= s8_ad_next;
            s8_zero_reg <= (s7_dep_reg == '0);
            s9_anx_reg  <= s9_anx_next;
            s9_any_reg  <= s9_any_next;
            s9_lim_reg  <= s9_lim_next;
            s9_ad_reg   <= s8_ad_reg;
            s9_sgx_reg  <= s8_mx_reg[PROD_W-1];
            s9_sgy_reg  <= s8_my_reg[PROD_W-1];
            s9_zero_reg <= s8_zero_reg;
            s10_vis_reg <= s10_vis_next;
            s10_sgx_reg <= s9_sgx_reg;
            s10_sgy_reg <= s9_sgy_reg;
            s10_na_reg  <= s10_na_next;
            s10_nb_reg  <= s10_nb_next;
            s10_den_reg <= s9_ad_reg;
        end
    end

    // screen coordinate magnitudes
    logic [QS_W-1:0] d1_qx, d1_qy;
    logic [2:0]      d1_tag;

    tpt_div2 #(
        .DEN_W (VAL_W),
        .Q_W   (QS_W),
        .TAG_W (3)
    ) u_div_screen (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (v_reg[NSTG-1]),
        .den     (s10_den_reg),
        .num_a   (s10_na_reg),
        .num_b   (s10_nb_reg),
        .tag     ({s10_vis_reg, s10_sgx_reg, s10_sgy_reg}),
        .out_vld (d1_vld),
        .quo_a   (d1_qx),
        .quo_b   (d1_qy),
        .tag_out (d1_tag)
    );

    logic [SS_W-1:0] p1_sumx, p1_sumy;
    logic [SP_W-1:0] p1_shx_reg, p1_shy_reg;
    logic            p1_vis_reg, p2_vis_reg, p3_vis_reg;
    logic [D2_R-1:0] p2_prx_reg, p2_pry_reg, p2_prx_next, p2_pry_next;
    logic [P3_W-1:0] p3_prx_reg, p3_pry_reg, p3_prx_next, p3_pry_next;

    always_comb
    begin
        // shift screen coordinate from (-h, h) to (0, 2h)
        p1_sumx = d1_tag[1] ? SS_W'(HALF) - SS_W'(d1_qx) : SS_W'(HALF) + SS_W'(d1_qx);
        p1_sumy = d1_tag[0] ? SS_W'(HALF) - SS_W'(d1_qy) : SS_W'(HALF) + SS_W'(d1_qy);
        p2_prx_next = D2_R'(p1_shx_reg) * D2_R'(PIXELS_X);
        p2_pry_next = D2_R'(p1_shy_reg) * D2_R'(PIXELS_Y);
        // divide by the span as a multiply by its scaled reciprocal
        p3_prx_next = P3_W'(p2_prx_reg) * P3_W'(RC_M[RC_W-1:0]);
        p3_pry_next = P3_W'(p2_pry_reg) * P3_W'(RC_M[RC_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_shx_reg <= p1_sumx[SP_W-1:0];
            p1_shy_reg <= p1_sumy[SP_W-1:0];
            p1_vis_reg <= d1_tag[2];
            p2_prx_reg <= p2_prx_next;
            p2_pry_reg <= p2_pry_next;
            p2_vis_reg <= p1_vis_reg;
            p3_prx_reg <= p3_prx_next;
            p3_pry_reg <= p3_pry_next;
            p3_vis_reg <= p2_vis_reg;
        end
    end

    assign out_valid = p_reg[2];

    always_comb
    begin
        out_data.visible = p3_vis_reg;
        out_data.pixel_x = p3_vis_reg ? PIX_X_W'(p3_prx_reg[RC_K +: QP_W]) : '0;
        out_data.pixel_y = p3_vis_reg ? PIX_Y_W'(p3_pry_reg[RC_K +: QP_W]) : '0;
    end

    `TPT_ASSERT_IMP(a_hidden_blank, out_valid && !out_data.visible,
        out_data.pixel_x == '0 && out_data.pixel_y == '0, "hidden word with pixel data")
    `TPT_ASSERT_NXT(a_zero_depth, adv && v_reg[8] && s9_zero_reg,
        !s10_vis_reg, "zero depth marked visible")
    `TPT_ASSERT_NXT(a_stall_freeze, !adv, $stable(v_reg) && $stable(p_reg),
        "pipeline valid bits moved during stall")

endmodule
